// ===== hdl/vec3_pkg.sv =====
// shared types, codes and helpers for the three-component vector unit
package vec3_pkg;

  localparam int FracBitsDef = 16;
  localparam int RootBits    = 32;
  localparam int DenBits     = 32;

  typedef enum logic [3:0] {
    ModeAdd   = 4'd0,
    ModeSub   = 4'd1,
    ModeScale = 4'd2,
    ModeDiv   = 4'd3,
    ModeNeg   = 4'd4,
    ModeDot   = 4'd5,
    ModeCross = 4'd6,
    ModeLen   = 4'd7,
    ModeNorm  = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrDivZero = 2'd1,
    ErrSat     = 2'd2
  } err_e;

  localparam logic signed [65:0] SatHi = 66'sd2147483647;
  localparam logic signed [65:0] SatLo = -66'sd2147483648;
  localparam logic [31:0] MaxPos = 32'h7fff_ffff;
  localparam logic [31:0] MinNeg = 32'h8000_0000;

  // context that rides alongside the square root
  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] r;
    logic [31:0]      s;
    logic             sat;
    logic [2:0][31:0] a;
    logic [31:0]      f;
  } vec3_ctx_t;

  // context that rides alongside the dividers
  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] r;
    logic [31:0]      s;
    logic             sat;
    logic             err;
    logic [2:0]       neg;
  } vec3_tail_t;

  // clamp to 32 bits, msb flags a clamp
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > SatHi) begin
      res = {1'b1, MaxPos};
    end else if (v < SatLo) begin
      res = {1'b1, MinNeg};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

// ===== hdl/vec3_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module vec3_isqrt import vec3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [2*RootBits-1:0]   rad_i,
  output logic [RootBits-1:0]     root_o
);

  logic [RootBits:0]     rem_q  [RootBits-1];
  logic [2*RootBits-1:0] rad_q  [RootBits-1];
  logic [RootBits-1:0]   root_q [RootBits];

  for (genvar k = 0; k < RootBits; k++) begin : g_stage
    logic [RootBits:0]     rem_in;
    logic [2*RootBits-1:0] rad_in;
    logic [RootBits-1:0]   root_in;
    logic [RootBits+2:0]   t;
    logic [RootBits+2:0]   trial;
    logic [RootBits+2:0]   rem_d;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign t     = {rem_in, rad_in[2*RootBits-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (t >= trial);
    assign rem_d = ge ? (t - trial) : t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[RootBits-2:0], ge};
      end
    end

    if (k < RootBits - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d[RootBits:0];
          rad_q[k] <= {rad_in[2*RootBits-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RootBits-1];

endmodule

// ===== hdl/vec3_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module vec3_div import vec3_pkg::*; #(
  parameter int W = 32 + FracBitsDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [W-1:0]       num_i,
  input  logic [DenBits-1:0] den_i,
  output logic [W-1:0]       quo_o
);

  logic [DenBits-1:0] rem_q [W-1];
  logic [DenBits-1:0] den_q [W-1];
  logic [W-1:0]       nq_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [DenBits-1:0] rem_in;
    logic [DenBits-1:0] den_in;
    logic [W-1:0]       nq_in;
    logic [DenBits:0]   t;
    logic [DenBits:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    assign t    = {rem_in, nq_in[W-1]};
    assign diff = t - {1'b0, den_in};
    assign ge   = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k] <= {nq_in[W-2:0], ge};
      end
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[DenBits-1:0] : t[DenBits-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = nq_q[W-1];

endmodule

// ===== hdl/vector3_alu.sv =====
// three-component vector unit, signed fixed point, fully pipelined
//
// usage: present a request on in_valid_i with mode_i, vectors a and b and
// factor_i; it is taken at an edge where in_valid_i is high and in_stall_o
// is low. one result per request comes out on out_valid_o with r_x/y/z,
// scalar_out and error, taken when out_stall_i is low.
// the path is two stages of multiply and sum, 32 square root stages, one
// setup stage, 32 + FRAC_BITS divider stages and the output register.
// every mode takes the same path so results stay in order.
// throughput is one request per cycle; a new request enters every cycle
// while the output is not stalled.
// when out_stall_i holds a waiting result, the whole pipeline freezes and
// in_stall_o rises; nothing is dropped or repeated.
// reset clears all valid bits; data registers are not reset.
module vector3_alu import vec3_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [31:0] factor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] r_x_o,
  output logic [31:0] r_y_o,
  output logic [31:0] r_z_o,
  output logic [31:0] scalar_out_o,
  output logic [1:0]  error_o
);

  localparam int W = 32 + FRAC_BITS;
  localparam int L = 4 + RootBits + W;
  localparam logic [W-1:0] PosLim = W'(MaxPos);
  localparam logic [W-1:0] NegLim = W'(MinNeg);

  logic         en;
  logic [L-1:0] v_q;

  assign en          = ~v_q[L-1] | ~out_stall_i;
  assign in_stall_o  = ~en;
  assign out_valid_o = v_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], in_valid_i};
    end
  end

  // stage 1: operand select, multipliers, add/sub/negate
  logic signed [31:0] a_v [3];
  logic signed [31:0] b_v [3];
  logic signed [31:0] op_a [6];
  logic signed [31:0] op_b [6];
  logic        [32:0] rs_d [3];

  logic signed [63:0] p1_q  [6];
  logic        [32:0] rs1_q [3];
  logic        [3:0]  mode1_q;
  logic [2:0][31:0]   a1_q;
  logic        [31:0] f1_q;

  assign a_v[0] = a_x_i;
  assign a_v[1] = a_y_i;
  assign a_v[2] = a_z_i;
  assign b_v[0] = b_x_i;
  assign b_v[1] = b_y_i;
  assign b_v[2] = b_z_i;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      op_a[k] = '0;
      op_b[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      rs_d[i] = '0;
    end
    case (mode_i)
      ModeAdd: begin
        for (int i = 0; i < 3; i++) rs_d[i] = {a_v[i][31], a_v[i]} + {b_v[i][31], b_v[i]};
      end
      ModeSub: begin
        for (int i = 0; i < 3; i++) rs_d[i] = {a_v[i][31], a_v[i]} - {b_v[i][31], b_v[i]};
      end
      ModeNeg: begin
        for (int i = 0; i < 3; i++) rs_d[i] = 33'd0 - {a_v[i][31], a_v[i]};
      end
      ModeScale: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = a_v[i];
          op_b[i] = factor_i;
        end
      end
      ModeDot: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = a_v[i];
          op_b[i] = b_v[i];
        end
      end
      ModeCross: begin
        op_a[0] = a_v[1]; op_b[0] = b_v[2];
        op_a[1] = a_v[2]; op_b[1] = b_v[1];
        op_a[2] = a_v[2]; op_b[2] = b_v[0];
        op_a[3] = a_v[0]; op_b[3] = b_v[2];
        op_a[4] = a_v[0]; op_b[4] = b_v[1];
        op_a[5] = a_v[1]; op_b[5] = b_v[0];
      end
      ModeLen, ModeNorm: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = a_v[i];
          op_b[i] = a_v[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) p1_q[k] <= op_a[k] * op_b[k];
      for (int i = 0; i < 3; i++) begin
        rs1_q[i]   <= rs_d[i];
        a1_q[i]    <= a_v[i];
      end
      mode1_q <= mode_i;
      f1_q    <= factor_i;
    end
  end

  // stage 2: sums, fixed-point shift, clamp, sum of squares
  logic signed [65:0] e   [6];
  logic signed [65:0] wv  [3];
  logic signed [65:0] dot;
  logic        [32:0] sv;
  vec3_ctx_t          ctx2_d;
  vec3_ctx_t          ctx2_q;
  logic [2*RootBits-1:0] rad2_d;
  logic [2*RootBits-1:0] rad2_q;

  always_comb begin
    for (int k = 0; k < 6; k++) e[k] = {{2{p1_q[k][63]}}, p1_q[k]};
    wv[0] = (e[0] - e[1]) >>> FRAC_BITS;
    wv[1] = (e[2] - e[3]) >>> FRAC_BITS;
    wv[2] = (e[4] - e[5]) >>> FRAC_BITS;
    dot   = (e[0] + e[1] + e[2]) >>> FRAC_BITS;
    sv    = '0;
    rad2_d = p1_q[0] + p1_q[1] + p1_q[2];

    ctx2_d.mode = mode1_q;
    ctx2_d.r    = '0;
    ctx2_d.s    = '0;
    ctx2_d.sat  = 1'b0;
    ctx2_d.a    = a1_q;
    ctx2_d.f    = f1_q;
    case (mode1_q)
      ModeAdd, ModeSub, ModeNeg: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32({{33{rs1_q[i][32]}}, rs1_q[i]});
          ctx2_d.r[i] = sv[31:0];
          ctx2_d.sat  = ctx2_d.sat | sv[32];
        end
      end
      ModeScale: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32(e[i] >>> FRAC_BITS);
          ctx2_d.r[i] = sv[31:0];
          ctx2_d.sat  = ctx2_d.sat | sv[32];
        end
      end
      ModeCross: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32(wv[i]);
          ctx2_d.r[i] = sv[31:0];
          ctx2_d.sat  = ctx2_d.sat | sv[32];
        end
      end
      ModeDot: begin
        sv = sat32(dot);
        ctx2_d.s   = sv[31:0];
        ctx2_d.sat = sv[32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx2_q <= ctx2_d;
      rad2_q <= rad2_d;
    end
  end

  // square root with matching context line
  logic [RootBits-1:0] root;
  vec3_ctx_t           ctx_q [RootBits];

  vec3_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad2_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx2_q;
      for (int k = 1; k < RootBits; k++) ctx_q[k] <= ctx_q[k-1];
    end
  end

  // stage 3: divider setup, length result, error detect
  vec3_ctx_t          cs;
  vec3_tail_t         tail3_d;
  vec3_tail_t         tail3_q;
  logic [DenBits-1:0] den3_d;
  logic [DenBits-1:0] den3_q;
  logic [W-1:0]       num3_d [3];
  logic [W-1:0]       num3_q [3];
  logic [31:0]        mag;

  assign cs = ctx_q[RootBits-1];

  always_comb begin
    tail3_d.mode = cs.mode;
    tail3_d.r    = cs.r;
    tail3_d.s    = cs.s;
    tail3_d.sat  = cs.sat;
    tail3_d.err  = 1'b0;
    mag          = '0;
    for (int i = 0; i < 3; i++) begin
      mag        = cs.a[i][31] ? (32'd0 - cs.a[i]) : cs.a[i];
      num3_d[i]  = {mag, {FRAC_BITS{1'b0}}};
      tail3_d.neg[i] = cs.a[i][31];
    end
    den3_d = root;
    case (cs.mode)
      ModeDiv: begin
        den3_d      = cs.f[31] ? (32'd0 - cs.f) : cs.f;
        tail3_d.err = (cs.f == '0);
        for (int i = 0; i < 3; i++) tail3_d.neg[i] = cs.a[i][31] ^ cs.f[31];
      end
      ModeNorm: begin
        tail3_d.err = (root == '0);
      end
      ModeLen: begin
        if (root > MaxPos) begin
          tail3_d.s   = MaxPos;
          tail3_d.sat = 1'b1;
        end else begin
          tail3_d.s   = root;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail3_q <= tail3_d;
      den3_q  <= den3_d;
      for (int i = 0; i < 3; i++) num3_q[i] <= num3_d[i];
    end
  end

  // dividers with matching context line
  logic [W-1:0] quo [3];
  vec3_tail_t   tail_q [W];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vec3_div #(.W(W)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num3_q[i]),
      .den_i (den3_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail3_q;
      for (int k = 1; k < W; k++) tail_q[k] <= tail_q[k-1];
    end
  end

  // final select and output register
  vec3_tail_t       tf;
  logic [2:0][31:0] r_d;
  logic [31:0]      s_d;
  logic [1:0]       err_d;
  logic             sat_f;
  logic [2:0][31:0] r_q;
  logic [31:0]      s_q;
  logic [1:0]       err_q;

  assign tf = tail_q[W-1];

  always_comb begin
    r_d   = tf.r;
    s_d   = tf.s;
    sat_f = tf.sat;
    if (tf.mode == ModeDiv || tf.mode == ModeNorm) begin
      for (int i = 0; i < 3; i++) begin
        if (tf.neg[i]) begin
          if (quo[i] > NegLim) begin
            r_d[i] = MinNeg;
            sat_f  = 1'b1;
          end else begin
            r_d[i] = 32'd0 - quo[i][31:0];
          end
        end else begin
          if (quo[i] > PosLim) begin
            r_d[i] = MaxPos;
            sat_f  = 1'b1;
          end else begin
            r_d[i] = quo[i][31:0];
          end
        end
      end
    end
    if (tf.err) begin
      r_d   = '0;
      s_d   = '0;
      err_d = ErrDivZero;
    end else if (sat_f) begin
      err_d = ErrSat;
    end else begin
      err_d = ErrNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= r_d;
      s_q   <= s_d;
      err_q <= err_d;
    end
  end

  assign r_x_o        = r_q[0];
  assign r_y_o        = r_q[1];
  assign r_z_o        = r_q[2];
  assign scalar_out_o = s_q;
  assign error_o      = err_q;

endmodule

// ===== hdl/vec3_alu_checker.sv =====
// port-level checks for the vector unit, bound to the top level
module vec3_alu_checker import vec3_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] r_x_o,
  input logic [31:0] r_y_o,
  input logic [31:0] r_z_o,
  input logic [31:0] scalar_out_o,
  input logic [1:0]  error_o
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r_x_o) && $stable(r_y_o)
      && $stable(r_z_o) && $stable(scalar_out_o) && $stable(error_o))
    else $error("stalled result changed");

  // the input side only stalls behind a held result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a result flagged divide-by-zero carries all-zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o == ErrDivZero |-> r_x_o == '0 && r_y_o == '0
      && r_z_o == '0 && scalar_out_o == '0)
    else $error("error result carries nonzero data");

  // only defined error codes leave the block
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_o == ErrNone || error_o == ErrDivZero || error_o == ErrSat)
    else $error("undefined error code");

  // handshake lines are always known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_stall_o, out_valid_o, out_stall_i}))
    else $error("unknown value on a handshake line");

endmodule

bind vector3_alu vec3_alu_checker u_vec3_alu_checker (.*);
